>>> design/lefr_pkg.sv
// Shared types and constants for the RGB Laplacian edge filter.
package lefr_pkg;

   localparam int MAX_WIDTH   = 512;
   localparam int LINE_AW     = $clog2(MAX_WIDTH);
   localparam int COL_W       = 10;
   localparam int ROW_W       = 12;
   localparam int OCNT_W      = 22;
   localparam int PIX_W       = 24;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 12;

   localparam int WIDTH_RESET  = 512;
   localparam int HEIGHT_RESET = 288;
   localparam int MIN_DIM      = 3;

   // command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = CSR_IDX_W'(1);

   typedef struct packed {
      logic       command;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } rsp_type;

   // control flags carried from the accept stage to the line-store stage
   typedef struct packed {
      logic write;
      logic emit;
      logic nonzero;
      logic frame_end;
   } stage_ctl_type;

endpackage

>>> design/laplacian_edge_filter_rgb_top.sv
// Top level of the streaming RGB 3x3 Laplacian edge filter.
//
// Usage:
//  - req channel: one transaction per pixel in raster order (command = pixel),
//    followed by width*height - (number of pixel results) flush transactions
//    once the frame's pixels are all in (the last width+1 outputs).
//  - rsp channel: one transaction per result; each pixel result belongs to
//    the pixel one row and one pixel earlier. Border pixels read 0. The last
//    flush result of a frame carries frame_end and rearms the counters.
//  - csr channel: index 0 = width_in_use, 1 = height_in_use. Write only while
//    idle. A write blocks req while width*height is refreshed.
// Timing: one transaction per clock sustained while rsp is not held. Each
//  result passes the line-store stage register, then the output register.
//  The rate is set by the single line-store RAM: one read at accept, one
//  write-back at stage exit, always at different columns: no forwarding needed.
// Stalls: if rsp is held, the output register keeps its result, one more
//  transaction is taken into the line-store stage, then req_ready drops.
// Reset: synchronous, active high. Counters, window and control registers clear;
//  line-store RAM and data registers are not cleared (stale entries feed only border pixels).
module laplacian_edge_filter_rgb_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lefr_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lefr_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lefr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lefr_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int CW = lefr_pkg::COL_W;
   localparam int RW = lefr_pkg::ROW_W;
   localparam int OW = lefr_pkg::OCNT_W;
   localparam int PW = lefr_pkg::PIX_W;
   localparam int AW = lefr_pkg::LINE_AW;

   // ---------------------------------------------------------------- config
   logic [CW-1:0]  width_ff;
   logic [RW-1:0]  height_ff;
   logic           cfg_hold_ff;
   logic [OW-1:0]  area_ff;
   logic [CW-1:0]  w_eff;
   logic [RW-1:0]  h_eff;
   logic           csr_accept;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= CW'(lefr_pkg::WIDTH_RESET);
         height_ff   <= RW'(lefr_pkg::HEIGHT_RESET);
         cfg_hold_ff <= 1'b0;
         area_ff     <= OW'(lefr_pkg::WIDTH_RESET * lefr_pkg::HEIGHT_RESET);
      end else begin
         cfg_hold_ff <= csr_accept;
         area_ff     <= OW'(w_eff) * OW'(h_eff);
         if (csr_accept) begin
            if (csr_index == lefr_pkg::REG_WIDTH) begin
               width_ff <= csr_data[CW-1:0];
            end else if (csr_index == lefr_pkg::REG_HEIGHT) begin
               height_ff <= csr_data[RW-1:0];
            end
         end
      end
   end

   // out-of-range settings are clamped
   always_comb begin
      priority if (width_ff < CW'(lefr_pkg::MIN_DIM)) begin
         w_eff = CW'(lefr_pkg::MIN_DIM);
      end else if (width_ff > CW'(lefr_pkg::MAX_WIDTH)) begin
         w_eff = CW'(lefr_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff < RW'(lefr_pkg::MIN_DIM)) ? RW'(lefr_pkg::MIN_DIM) : height_ff;
   end

   // ---------------------------------------------------------------- handshake
   logic                     s1_valid_ff;
   lefr_pkg::stage_ctl_type  s1_ctl_ff;
   logic [AW-1:0]            s1_addr_ff;
   logic [PW-1:0]            s1_px_ff;
   logic                     rsp_valid_ff;
   lefr_pkg::rsp_type        rsp_data_ff;
   logic                     out_free;
   logic                     s1_adv;
   logic                     req_accept;

   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign s1_adv     = s1_valid_ff & (~s1_ctl_ff.emit | out_free);
   assign req_ready  = (~s1_valid_ff | s1_adv) & ~cfg_hold_ff;
   assign req_accept = req_valid & req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------------------------------------------------------- accept stage
   logic [CW-1:0]            col_ff, col_in;
   logic [RW-1:0]            row_ff, row_in;
   logic [OW-1:0]            ocnt_ff, ocnt_in;
   lefr_pkg::stage_ctl_type  s0_ctl;
   logic [CW:0]              col_plus;
   logic [OW:0]              ocnt_plus;

   assign col_plus  = {1'b0, col_ff} + (CW+1)'(1);
   assign ocnt_plus = {1'b0, ocnt_ff} + (OW+1)'(1);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      ocnt_in = ocnt_ff;
      s0_ctl  = '0;
      if (req_data.command == lefr_pkg::CMD_FLUSH) begin
         // flushes count only once every pixel of the frame is in
         if (row_ff >= h_eff) begin
            s0_ctl.emit = 1'b1;
            if (ocnt_plus >= {1'b0, area_ff}) begin
               s0_ctl.frame_end = 1'b1;
               col_in  = '0;
               row_in  = '0;
               ocnt_in = '0;
            end else begin
               ocnt_in = ocnt_plus[OW-1:0];
            end
         end
      end else if (row_ff < h_eff) begin
         s0_ctl.write   = 1'b1;
         s0_ctl.emit    = (row_ff >= RW'(2)) || (row_ff == RW'(1) && col_ff != '0);
         s0_ctl.nonzero = (row_ff >= RW'(2)) && (col_ff >= CW'(2)) && (col_ff < w_eff);
         if (s0_ctl.emit) begin
            ocnt_in = ocnt_plus[OW-1:0];
         end
         if (col_plus >= {1'b0, w_eff}) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_plus[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         ocnt_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s1_ctl_ff   <= '0;
      end else begin
         if (req_accept) begin
            col_ff      <= col_in;
            row_ff      <= row_in;
            ocnt_ff     <= ocnt_in;
            s1_valid_ff <= 1'b1;
            s1_ctl_ff   <= s0_ctl;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff <= col_ff[AW-1:0];
         s1_px_ff   <= {req_data.red_in, req_data.green_in, req_data.blue_in};
      end
   end

   // ---------------------------------------------------------------- line store
   // each entry: upper row in 47:24, middle row in 23:0
   logic [2*PW-1:0] line_mem [lefr_pkg::MAX_WIDTH];
   logic [2*PW-1:0] line_rd_ff;
   logic            mem_we;
   logic [PW-1:0]   top_px;
   logic [PW-1:0]   mid_px;

   assign top_px = line_rd_ff[2*PW-1:PW];
   assign mid_px = line_rd_ff[PW-1:0];
   assign mem_we = s1_adv & s1_ctl_ff.write;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[s1_addr_ff] <= {mid_px, s1_px_ff};
      end
      if (req_accept) begin
         line_rd_ff <= line_mem[col_ff[AW-1:0]];
      end
   end

   // ---------------------------------------------------------------- window
   logic [PW-1:0] win_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (mem_we) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_px;
         win_ff[4] <= mid_px;
         win_ff[5] <= s1_px_ff;
      end
   end

   // 8*centre minus the eight neighbours of one channel, clamped to 0..255
   function automatic logic [7:0] lap_chan(input logic [7:0] c,
                                           input logic [7:0] n0, input logic [7:0] n1,
                                           input logic [7:0] n2, input logic [7:0] n3,
                                           input logic [7:0] n4, input logic [7:0] n5,
                                           input logic [7:0] n6, input logic [7:0] n7);
      logic [10:0] sum;
      logic [11:0] diff;
      logic [7:0]  res;
      sum  = ((11'(n0) + 11'(n1)) + (11'(n2) + 11'(n3)))
           + ((11'(n4) + 11'(n5)) + (11'(n6) + 11'(n7)));
      diff = {1'b0, c, 3'b000} - {1'b0, sum};
      if (diff[11]) begin
         res = 8'd0;
      end else if (diff[10:8] != 3'b000) begin
         res = 8'd255;
      end else begin
         res = diff[7:0];
      end
      return res;
   endfunction

   logic [7:0] lap_r, lap_g, lap_b;

   always_comb begin
      lap_r = lap_chan(win_ff[4][23:16], win_ff[0][23:16], win_ff[1][23:16],
                       win_ff[2][23:16], win_ff[3][23:16], win_ff[5][23:16],
                       top_px[23:16], mid_px[23:16], s1_px_ff[23:16]);
      lap_g = lap_chan(win_ff[4][15:8], win_ff[0][15:8], win_ff[1][15:8],
                       win_ff[2][15:8], win_ff[3][15:8], win_ff[5][15:8],
                       top_px[15:8], mid_px[15:8], s1_px_ff[15:8]);
      lap_b = lap_chan(win_ff[4][7:0], win_ff[0][7:0], win_ff[1][7:0],
                       win_ff[2][7:0], win_ff[3][7:0], win_ff[5][7:0],
                       top_px[7:0], mid_px[7:0], s1_px_ff[7:0]);
   end

   // ---------------------------------------------------------------- output register
   logic out_load;
   assign out_load = s1_adv & s1_ctl_ff.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff.red_out   <= s1_ctl_ff.nonzero ? lap_r : 8'd0;
         rsp_data_ff.green_out <= s1_ctl_ff.nonzero ? lap_g : 8'd0;
         rsp_data_ff.blue_out  <= s1_ctl_ff.nonzero ? lap_b : 8'd0;
         rsp_data_ff.frame_end <= s1_ctl_ff.frame_end;
      end
   end

   // ---------------------------------------------------------------- assertions
   a_no_same_col : assert property (@(posedge clock) disable iff (reset)
      (mem_we && req_accept) |-> (s1_addr_ff != col_ff[AW-1:0]))
      else $error("line store read and write-back hit the same column");

   a_hold_after_csr : assert property (@(posedge clock) disable iff (reset)
      csr_accept |=> !req_ready)
      else $error("req accepted before frame area was refreshed");

   a_stall_only_full : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> (rsp_valid_ff && !rsp_ready))
      else $error("line-store stage stalled with output register free");

   a_frame_end_zero : assert property (@(posedge clock) disable iff (reset)
      (out_load && s1_ctl_ff.frame_end) |-> (!s1_ctl_ff.nonzero && !s1_ctl_ff.write))
      else $error("frame end on a pixel result");

   a_col_in_range : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (col_ff < CW'(lefr_pkg::MAX_WIDTH)))
      else $error("column counter beyond line store depth");

endmodule

>>> test/tb_laplacian_edge_filter_rgb_top.sv
// Self-checking testbench for the streaming RGB 3x3 Laplacian edge filter.
`timescale 1ns / 100ps

import lefr_pkg::*;

class edge_map_checker;
   typedef logic [PIX_W-1:0] pixel_word;

   logic [COL_W-1:0] width_reg;
   logic [ROW_W-1:0] height_reg;
   pixel_word        upper_row [MAX_WIDTH];
   pixel_word        middle_row [MAX_WIDTH];
   pixel_word        win [6];
   int               col_pos;
   int               row_pos;
   int               out_cnt;
   int               seen;
   int               errors;
   rsp_type          edge_queue [$];

   function new();
      width_reg  = COL_W'(WIDTH_RESET);
      height_reg = ROW_W'(HEIGHT_RESET);
      foreach (upper_row[i]) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      out_cnt = 0;
      seen    = 0;
      errors  = 0;
   endfunction

   function int eff_width();
      int w;
      w = int'(width_reg);
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function int eff_height();
      return (int'(height_reg) < MIN_DIM) ? MIN_DIM : int'(height_reg);
   endfunction

   function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      if (idx == REG_WIDTH) width_reg = value[COL_W-1:0];
      else if (idx == REG_HEIGHT) height_reg = value[ROW_W-1:0];
   endfunction

   function int pending();
      return edge_queue.size();
   endfunction

   function bit frame_filled();
      return row_pos >= eff_height();
   endfunction

   function bit at_frame_start();
      return row_pos == 0 && col_pos == 0 && out_cnt == 0;
   endfunction

   // 8 * centre minus the eight neighbours, one channel, clamped to 0..255
   function logic [7:0] lap(pixel_word nb [8], pixel_word ctr, int sh);
      int s;
      s = 8 * int'(ctr[sh +: 8]);
      for (int i = 0; i < 8; i++) s -= int'(nb[i][sh +: 8]);
      if (s < 0) s = 0;
      if (s > 255) s = 255;
      return 8'(s);
   endfunction

   // Returns 1 when the transaction belongs to the frame, 0 when it is ignored.
   function bit predict_edge(req_type t);
      int        w;
      int        h;
      int        col;
      pixel_word top;
      pixel_word mid;
      pixel_word bot;
      pixel_word nb [8];
      rsp_type   r;
      w = eff_width();
      h = eff_height();
      col = col_pos;
      r = '0;
      if (t.command == CMD_FLUSH) begin
         if (row_pos < h) return 0;
         if (out_cnt + 1 >= w * h) begin
            r.frame_end = 1'b1;
            row_pos = 0;
            col_pos = 0;
            out_cnt = 0;
         end else begin
            out_cnt = (out_cnt + 1) & 32'h3F_FFFF;
         end
         edge_queue.push_back(r);
         return 1;
      end
      if (row_pos >= h) return 0;
      col = col % MAX_WIDTH;
      top = upper_row[col];
      mid = middle_row[col];
      bot = {t.red_in, t.green_in, t.blue_in};
      if (row_pos >= 2 || (row_pos == 1 && col >= 1)) begin
         // interior positions only; every border position reads 0
         if (col >= 1 && row_pos - 1 != 0 && row_pos - 1 < h - 1
               && col - 1 != 0 && col - 1 < w - 1) begin
            nb = '{win[0], win[1], win[2], win[3], win[5], top, mid, bot};
            r.red_out   = lap(nb, win[4], 16);
            r.green_out = lap(nb, win[4], 8);
            r.blue_out  = lap(nb, win[4], 0);
         end
         out_cnt = (out_cnt + 1) & 32'h3F_FFFF;
         edge_queue.push_back(r);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = bot;
      upper_row[col]  = mid;
      middle_row[col] = bot;
      if (col + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1) & 32'hFFF;
      end else begin
         col_pos = col + 1;
      end
      return 1;
   endfunction

   task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_edge(rsp_type got);
      rsp_type want;
      seen++;
      if (edge_queue.size() == 0) begin
         report_mismatch($sformatf("result %0d arrived with none expected", seen));
         return;
      end
      want = edge_queue.pop_front();
      if (got.red_out !== want.red_out)
         report_mismatch($sformatf("result %0d red_out %h, expected %h",
                                   seen, got.red_out, want.red_out));
      if (got.green_out !== want.green_out)
         report_mismatch($sformatf("result %0d green_out %h, expected %h",
                                   seen, got.green_out, want.green_out));
      if (got.blue_out !== want.blue_out)
         report_mismatch($sformatf("result %0d blue_out %h, expected %h",
                                   seen, got.blue_out, want.blue_out));
      if (got.frame_end !== want.frame_end)
         report_mismatch($sformatf("result %0d frame_end %b, expected %b",
                                   seen, got.frame_end, want.frame_end));
   endtask

   task finish();
      if (edge_queue.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   edge_queue.size()));
   endtask
endclass

module tb_laplacian_edge_filter_rgb_top;

   localparam int RANDOM_ITEMS  = 300;
   localparam int LATENCY_PAUSE = 4;     // output register plus line-store stage
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int QUIET_LIMIT   = 4000;  // cycles without any transaction
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = {CSR_IDX_W{1'b1}};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   edge_map_checker edges;

   bit steady      = 1'b0;   // no idling on either side while set
   int hold_asked  = 0;      // bumped by the sender to request a receiver hold-off
   int hold_given  = 0;
   int hold_left   = 0;
   int hold_at     = -1;     // pixel index in a frame that triggers the hold-off
   int drain_at    = -1;     // pixel index in a frame where the sender drains
   int taken_items = 0;      // transactions that belonged to a frame
   int quiet       = 0;

   laplacian_edge_filter_rgb_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver: random back-pressure, plus a long hold-off on request. The
   // hold-off is counted here so the sender keeps offering transactions and
   // the block fills up and stalls its input.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_asked != hold_given) begin
         hold_given = hold_asked;
         hold_left  = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(0, 99) >= 34);
      end
   end

   // Result monitor and watchdog. Values are sampled before this edge's updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) edges.check_edge(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
               || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("** laplacian_edge_filter_rgb_top: FAILED **");
            $finish;
         end
      end
   end

   function automatic req_type pixel_item(logic [23:0] px);
      req_type t;
      t.command  = CMD_PIXEL;
      t.red_in   = px[23:16];
      t.green_in = px[15:8];
      t.blue_in  = px[7:0];
      return t;
   endfunction

   // colour fields of a flush are don't-care, so they carry noise
   function automatic req_type flush_item();
      req_type t;
      t = pixel_item(24'($urandom));
      t.command = CMD_FLUSH;
      return t;
   endfunction

   // Mix of saturated, flat and fully random pixels so both clamps get hit.
   function automatic logic [23:0] rand_pixel();
      logic [23:0] p;
      logic [7:0]  base;
      p = 24'($urandom);
      base = 8'($urandom);
      case ($urandom_range(0, 3))
         0: for (int c = 0; c < 3; c++) p[c*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         1: for (int c = 0; c < 3; c++) p[c*8 +: 8] = base ^ 8'($urandom_range(0, 7));
         default: ;
      endcase
      return p;
   endfunction

   // Offer one req transaction, hold it until accepted, then maybe idle.
   task automatic send_req(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (edges.predict_edge(item)) taken_items++;
      while (!steady && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Stop offering and wait until every expected result is back, then let the
   // pipeline settle in case the last transaction was one the block ignores.
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (edges.pending() != 0) @(posedge clock);
      repeat (LATENCY_PAUSE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      edges.set_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Width goes in with random don't-care bits above the 10-bit field.
   task automatic configure(input int w, input int h);
      quiesce();
      csr_write(REG_WIDTH, {2'($urandom), 10'(w)});
      csr_write(REG_HEIGHT, 12'(h));
      if ($urandom_range(0, 7) == 0) csr_write(REG_UNUSED, 12'($urandom));
   endtask

   // Flush transactions until the frame closes with frame_end.
   task automatic finish_frame(input bit noisy);
      if (noisy) repeat ($urandom_range(1, 3)) send_req(pixel_item(rand_pixel()));
      do send_req(flush_item()); while (!edges.at_frame_start());
   endtask

   // Pixels in raster order until the frame is full (or pixel_limit is hit),
   // then the trailing flushes. Noisy frames carry early flushes and surplus
   // pixels, which the block must drop.
   task automatic run_frame(input int pixel_limit, input bit noisy);
      int sent;
      sent = 0;
      while (!edges.frame_filled() && sent != pixel_limit) begin
         if (noisy && $urandom_range(0, 15) == 0) send_req(flush_item());
         send_req(pixel_item(rand_pixel()));
         sent++;
         if (sent == hold_at) hold_asked++;
         if (sent == drain_at) quiesce();
      end
      if (edges.frame_filled()) finish_frame(noisy);
   endtask

   initial begin
      int base_items;
      int w;
      int h;
      edges = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: out-of-range registers clamp to a 3x3 frame. Early flush is
      // dropped; the single interior pixel saturates red high, green low and
      // leaves blue unclamped; surplus pixels are dropped before the flushes.
      configure(0, 1);
      send_req(flush_item());
      for (int i = 0; i < 9; i++)
         send_req(pixel_item(i == 4 ? 24'hFF0020 : 24'h00FF10));
      finish_frame(1'b1);

      // Height raised mid-frame while the block is idle.
      configure(5, 3);
      run_frame(10, 1'b0);
      quiesce();
      csr_write(REG_HEIGHT, 12'd5);
      run_frame(-1, 1'b0);

      // Whole frame streamed with no idling on either side.
      steady = 1'b1;
      configure(24, 4);
      run_frame(-1, 1'b0);
      steady = 1'b0;

      // Long receiver hold-off while results flow, then a full drain.
      hold_at  = 30;
      drain_at = 80;
      configure(20, 6);
      run_frame(-1, 1'b0);
      hold_at  = -1;
      drain_at = -1;

      // Random frames, mostly small, some with noise.
      base_items = taken_items;
      while (taken_items - base_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0: w = $urandom_range(0, 2);
            1: w = $urandom_range(11, 40);
            default: w = $urandom_range(3, 10);
         endcase
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
         configure(w, h);
         run_frame(-1, $urandom_range(0, 3) == 0);
      end

      quiesce();
      repeat (LATENCY_PAUSE) @(posedge clock);
      edges.finish();
      if (edges.errors == 0)
         $display("** laplacian_edge_filter_rgb_top: PASSED **");
      else
         $display("** laplacian_edge_filter_rgb_top: FAILED **");
      $finish;
   end

endmodule
